/* hdl/pid_tagged_lru_tlb_top_macros.svh */
// ----------------------------------------------------------------------------
// pid_tagged_lru_tlb_top_macros
// Assertion macros used by the translation buffer top module.
// ----------------------------------------------------------------------------
`ifndef PID_TAGGED_LRU_TLB_TOP_MACROS_SVH
`define PID_TAGGED_LRU_TLB_TOP_MACROS_SVH

`ifndef ASSERT_OFF

// Condition holds at every clock edge out of reset.
`define PTLB_ASSERT_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("assertion failed: invariant");

// Antecedent implies consequent in the same cycle.
`define PTLB_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: implication");

// Antecedent implies consequent in the following cycle.
`define PTLB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`else

`define PTLB_ASSERT_ALWAYS(label, clk, rst_n, cond)
`define PTLB_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define PTLB_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* hdl/ptlb_pkg.sv */
// ----------------------------------------------------------------------------
// ptlb_pkg
// Types and constants of the process-tagged LRU translation buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package ptlb_pkg;

	localparam int PID_W   = 16;
	localparam int PAGE_W  = 20;
	localparam int FRAME_W = 16;
	localparam int REQ_W   = 2;
	localparam int LIM_W   = 5;
	localparam int VCNT_W  = 5;

	localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd0;
	localparam logic [REQ_W-1:0] REQ_FILL   = 2'd1;
	localparam logic [REQ_W-1:0] REQ_SWITCH = 2'd2;
	localparam logic [REQ_W-1:0] REQ_NOP    = 2'd3;

	localparam logic [LIM_W-1:0] LIMIT_RESET = 5'd16;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} tlb_state_t;

	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_MARK,
		CELL_FILL,
		CELL_LOOKUP,
		CELL_SQUEEZE
	} cell_op_t;

	typedef struct packed {
		logic               valid;
		logic [PID_W-1:0]   pid;
		logic [PAGE_W-1:0]  page;
		logic [FRAME_W-1:0] frame;
	} tlb_entry_t;

	typedef struct packed {
		cell_op_t           op;
		logic [PID_W-1:0]   active_pid;
		logic [PAGE_W-1:0]  page;
		logic [FRAME_W-1:0] frame;
		logic [LIM_W-1:0]   limit;
		logic               mark_en;
		logic               match_page;
		logic               any;
	} cell_ctl_t;

endpackage

`default_nettype wire

/* hdl/ptlb_cell.sv */
// ----------------------------------------------------------------------------
// ptlb_cell
// One slot of the most-recent-first entry chain, with its match mark.
// ----------------------------------------------------------------------------
`default_nettype none

module ptlb_cell #(
	parameter int IDX = 0
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  ptlb_pkg::cell_ctl_t ctl,
	input  ptlb_pkg::tlb_entry_t prev_entry,
	input  ptlb_pkg::tlb_entry_t next_entry,
	input  wire                 next_mark,
	input  ptlb_pkg::tlb_entry_t sel_entry,
	input  wire                 ahead,
	output ptlb_pkg::tlb_entry_t entry,
	output logic                mark
);

	logic                         valid_q;
	logic                         mark_q;
	logic [ptlb_pkg::PID_W-1:0]   pid_q;
	logic [ptlb_pkg::PAGE_W-1:0]  page_q;
	logic [ptlb_pkg::FRAME_W-1:0] frame_q;
	ptlb_pkg::tlb_entry_t         ent_cur;
	ptlb_pkg::tlb_entry_t         ent_d;
	logic                         mark_d;

	assign ent_cur = '{valid: valid_q, pid: pid_q, page: page_q, frame: frame_q};

	always_comb begin
		ent_d  = ent_cur;
		mark_d = mark_q;
		unique case (ctl.op)
			ptlb_pkg::CELL_HOLD: begin
			end
			ptlb_pkg::CELL_MARK: begin
				mark_d = valid_q && ctl.mark_en && (pid_q == ctl.active_pid)
					&& (!ctl.match_page || (page_q == ctl.page));
			end
			ptlb_pkg::CELL_FILL: begin
				mark_d = 1'b0;
				if (IDX == 0) begin
					ent_d = '{valid: 1'b1, pid: ctl.active_pid, page: ctl.page,
						frame: ctl.frame};
				end else begin
					ent_d       = prev_entry;
					ent_d.valid = prev_entry.valid && (int'(ctl.limit) > IDX);
				end
			end
			ptlb_pkg::CELL_LOOKUP: begin
				mark_d = 1'b0;
				if (ctl.any) begin
					if (IDX == 0) begin
						ent_d = sel_entry;
					end else if (!ahead) begin
						ent_d = prev_entry;
					end
				end
			end
			ptlb_pkg::CELL_SQUEEZE: begin
				if (ahead || mark_q) begin
					ent_d  = next_entry;
					mark_d = next_mark;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			mark_q  <= 1'b0;
		end else begin
			valid_q <= ent_d.valid;
			mark_q  <= mark_d;
		end
	end

	always_ff @(posedge clk) begin
		pid_q   <= ent_d.pid;
		page_q  <= ent_d.page;
		frame_q <= ent_d.frame;
	end

	assign entry = ent_cur;
	assign mark  = mark_q;

endmodule

`default_nettype wire

/* hdl/pid_tagged_lru_tlb_top.sv */
// ----------------------------------------------------------------------------
// pid_tagged_lru_tlb_top
// Fully associative process-tagged translation buffer in true LRU order.
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  request   start / busy           req_type, new_pid, page_number, frame_in
//  result    done (one-cycle pulse) hit, frame_out, valid_entries
//  config    cfg_valid / cfg_ready  cfg_data (entry limit)
//
//  Lookup, fill and no-op: a compare step in every cell, then one move step.
//  Switch: compare, one squeeze per entry flushed, then finish; the chain closes one gap a cycle.
//  done pulses the cycle after the last move; start is taken in that cycle.
//  Reset invalidates all cells and clears the active pid; results cannot be held off.
// ----------------------------------------------------------------------------
`default_nettype none

`include "pid_tagged_lru_tlb_top_macros.svh"

module pid_tagged_lru_tlb_top #(
	parameter int TLB_DEPTH = 16
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           start,
	output logic                          busy,
	input  wire [ptlb_pkg::REQ_W-1:0]     req_type,
	input  wire [ptlb_pkg::PID_W-1:0]     new_pid,
	input  wire [ptlb_pkg::PAGE_W-1:0]    page_number,
	input  wire [ptlb_pkg::FRAME_W-1:0]   frame_in,
	output logic                          done,
	output logic                          hit,
	output logic [ptlb_pkg::FRAME_W-1:0]  frame_out,
	output logic [ptlb_pkg::VCNT_W-1:0]   valid_entries,
	input  wire                           cfg_valid,
	output logic                          cfg_ready,
	input  wire [ptlb_pkg::LIM_W-1:0]     cfg_data
);

	localparam int CNT_W = $clog2(TLB_DEPTH + 1);
	localparam int LW    = (CNT_W > ptlb_pkg::LIM_W) ? CNT_W : ptlb_pkg::LIM_W;

	ptlb_pkg::tlb_state_t          state_q, state_d;
	logic [ptlb_pkg::REQ_W-1:0]    req_q;
	logic [ptlb_pkg::PID_W-1:0]    new_pid_q;
	logic [ptlb_pkg::PAGE_W-1:0]   page_q;
	logic [ptlb_pkg::FRAME_W-1:0]  frame_q;
	logic [ptlb_pkg::PID_W-1:0]    active_pid_q;
	logic [ptlb_pkg::LIM_W-1:0]    limit_q;
	logic [CNT_W-1:0]              count_q, count_d;
	logic                          done_q, hit_q;
	logic [ptlb_pkg::FRAME_W-1:0]  frame_out_q;
	logic [ptlb_pkg::VCNT_W-1:0]   valid_entries_q;

	ptlb_pkg::tlb_entry_t          entry_vec [TLB_DEPTH];
	logic [TLB_DEPTH-1:0]          mark_vec;
	logic [TLB_DEPTH-1:0]          before_vec;
	logic [TLB_DEPTH-1:0]          first_vec;
	logic [TLB_DEPTH-1:0]          valid_vec;
	ptlb_pkg::tlb_entry_t          sel_entry;
	ptlb_pkg::cell_ctl_t           ctl;
	ptlb_pkg::cell_op_t            cell_op;
	logic                          any_mark;
	logic                          hit_now;
	logic                          accept;
	logic                          fin;
	logic                          squeeze;

	logic [LW-1:0]                 lim_w, eff_lim, cnt_w, keep_w;

	assign accept   = start && !busy;
	assign any_mark = before_vec[TLB_DEPTH-1] || mark_vec[TLB_DEPTH-1];
	assign hit_now  = (req_q == ptlb_pkg::REQ_LOOKUP) && any_mark;

	// Prefix of marks ahead of each cell, and first-match select.
	genvar gi;
	generate
		for (gi = 0; gi < TLB_DEPTH; gi++) begin : g_pre
			if (gi == 0) begin : g_head
				assign before_vec[gi] = 1'b0;
			end else begin : g_rest
				assign before_vec[gi] = |mark_vec[gi-1:0];
			end
			assign first_vec[gi] = mark_vec[gi] && !before_vec[gi];
			assign valid_vec[gi] = entry_vec[gi].valid;
		end
	endgenerate

	always_comb begin
		sel_entry = '0;
		for (int i = 0; i < TLB_DEPTH; i++) begin
			sel_entry = sel_entry
				| (entry_vec[i] & {$bits(ptlb_pkg::tlb_entry_t){first_vec[i]}});
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ptlb_pkg::ST_IDLE: begin
				if (start) begin
					state_d = ptlb_pkg::ST_EXEC;
				end
			end
			ptlb_pkg::ST_EXEC: begin
				if (fin) begin
					state_d = ptlb_pkg::ST_IDLE;
				end
			end
		endcase
	end

	// Outputs of the controller.
	always_comb begin
		cell_op = ptlb_pkg::CELL_HOLD;
		fin     = 1'b0;
		squeeze = 1'b0;
		busy    = 1'b0;
		unique case (state_q)
			ptlb_pkg::ST_IDLE: begin
				if (start) begin
					cell_op = ptlb_pkg::CELL_MARK;
				end
			end
			ptlb_pkg::ST_EXEC: begin
				busy = 1'b1;
				unique case (req_q)
					ptlb_pkg::REQ_LOOKUP: begin
						cell_op = ptlb_pkg::CELL_LOOKUP;
						fin     = 1'b1;
					end
					ptlb_pkg::REQ_FILL: begin
						cell_op = ptlb_pkg::CELL_FILL;
						fin     = 1'b1;
					end
					ptlb_pkg::REQ_SWITCH: begin
						if (any_mark) begin
							cell_op = ptlb_pkg::CELL_SQUEEZE;
							squeeze = 1'b1;
						end else begin
							fin = 1'b1;
						end
					end
					default: begin
						fin = 1'b1;
					end
				endcase
			end
		endcase
	end

	always_comb begin
		ctl.op         = cell_op;
		ctl.active_pid = active_pid_q;
		ctl.page       = (state_q == ptlb_pkg::ST_IDLE) ? page_number : page_q;
		ctl.frame      = frame_q;
		ctl.limit      = limit_q;
		ctl.mark_en    = (req_type == ptlb_pkg::REQ_LOOKUP)
			|| ((req_type == ptlb_pkg::REQ_SWITCH) && (active_pid_q != '0));
		ctl.match_page = (req_type == ptlb_pkg::REQ_LOOKUP);
		ctl.any        = any_mark;
	end

	// Occupancy after a fill: min(count, L - 1) + 1, L the limit clamped to 1..TLB_DEPTH.
	always_comb begin
		lim_w = LW'(limit_q);
		cnt_w = LW'(count_q);
		if (lim_w == '0) begin
			eff_lim = LW'(1);
		end else if (lim_w > LW'(TLB_DEPTH)) begin
			eff_lim = LW'(TLB_DEPTH);
		end else begin
			eff_lim = lim_w;
		end
		keep_w = (cnt_w > eff_lim - LW'(1)) ? (eff_lim - LW'(1)) : cnt_w;
		count_d = count_q;
		if (state_q == ptlb_pkg::ST_EXEC) begin
			if (req_q == ptlb_pkg::REQ_FILL) begin
				count_d = CNT_W'(keep_w + LW'(1));
			end else if (squeeze) begin
				count_d = CNT_W'(count_q - CNT_W'(1));
			end
		end
	end

	generate
		for (gi = 0; gi < TLB_DEPTH; gi++) begin : g_cell
			ptlb_pkg::tlb_entry_t prev_e;
			ptlb_pkg::tlb_entry_t next_e;
			logic                 next_m;
			if (gi == 0) begin : g_first
				assign prev_e = '0;
			end else begin : g_prev
				assign prev_e = entry_vec[gi-1];
			end
			if (gi == TLB_DEPTH - 1) begin : g_last
				assign next_e = '0;
				assign next_m = 1'b0;
			end else begin : g_next
				assign next_e = entry_vec[gi+1];
				assign next_m = mark_vec[gi+1];
			end
			ptlb_cell #(
				.IDX(gi)
			) u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctl        (ctl),
				.prev_entry (prev_e),
				.next_entry (next_e),
				.next_mark  (next_m),
				.sel_entry  (sel_entry),
				.ahead      (before_vec[gi]),
				.entry      (entry_vec[gi]),
				.mark       (mark_vec[gi])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ptlb_pkg::ST_IDLE;
			active_pid_q <= '0;
			limit_q      <= ptlb_pkg::LIMIT_RESET;
			count_q      <= '0;
			done_q       <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			done_q  <= fin;
			if (cfg_valid && cfg_ready) begin
				limit_q <= cfg_data;
			end
			if (fin && (req_q == ptlb_pkg::REQ_SWITCH)) begin
				active_pid_q <= new_pid_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q     <= req_type;
			new_pid_q <= new_pid;
			page_q    <= page_number;
			frame_q   <= frame_in;
		end
		if (fin) begin
			hit_q           <= hit_now;
			frame_out_q     <= hit_now ? sel_entry.frame : '0;
			valid_entries_q <= ptlb_pkg::VCNT_W'(count_d);
		end
	end

	assign cfg_ready     = 1'b1;
	assign done          = done_q;
	assign hit           = hit_q;
	assign frame_out     = frame_out_q;
	assign valid_entries = valid_entries_q;

	`PTLB_ASSERT_ALWAYS(a_valid_compact, clk, arst_n, (valid_vec & (valid_vec + 1'b1)) == '0)
	`PTLB_ASSERT_ALWAYS(a_count_matches, clk, arst_n, $countones(valid_vec) == int'(count_q))
	`PTLB_ASSERT_IMPLY(a_idle_no_marks, clk, arst_n, state_q == ptlb_pkg::ST_IDLE, mark_vec == '0)
	`PTLB_ASSERT_NEXT(a_hit_front, clk, arst_n, fin && hit_now, hit_q && entry_vec[0].valid)

endmodule

`default_nettype wire
